>>> design/cle_pkg.sv
// Package for the cursor list editor: opcode and status codes, widths of
// the result fields, and the result record. No dependencies.
`timescale 1ns / 1ps
package cle_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int LEN_W = 7;
  localparam int POS_W = 6;

  typedef enum logic [3:0] {
    OP_INS_AFTER = 4'd0,
    OP_INS_HEAD  = 4'd1,
    OP_FRONT     = 4'd2,
    OP_REAR      = 4'd3,
    OP_PREV      = 4'd4,
    OP_NEXT      = 4'd5,
    OP_SEEK      = 4'd6,
    OP_DELETE    = 4'd7,
    OP_REPLACE   = 4'd8,
    OP_READ      = 4'd9,
    OP_LIST      = 4'd10,
    OP_REVERSE   = 4'd11,
    OP_FIND      = 4'd12,
    OP_COUNT     = 4'd13,
    OP_DEDUPE    = 4'd14,
    OP_CLEAR     = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } stat_t;

  typedef struct packed {
    stat_t             status;
    logic [7:0]        item;
    logic [LEN_W-1:0]  idx;
    logic              atc;
    logic [LEN_W-1:0]  mc;
  } res_t;

endpackage

>>> design/cursor_list_editor_unit.sv
// Cursor list editor top level: character memory, sequencer and output word
// register. Depends on cle_pkg.
`timescale 1ns / 1ps
// Channel | Handshake           | Word
// input   | in_valid, in_stall  | opcode, value, seek_index
// output  | out_valid, out_stall| status, item, item_index, at_cursor, match_count,
//         |                     | list_length, is_empty, cursor_position, last
// One memory port pair does all the work, with one read or one write per cycle.
// Navigation, replace and clear finish straight from idle; insert and delete
// move each item with a read and a write; find, count, list and reverse read each item in turn;
// dedupe reads and compares each pair, up to DEPTH*DEPTH pairs.
// Reset empties the list at once; the memory holds no reset state.
// A stalled output word holds the sequencer only when it has a new word.
module cursor_list_editor_unit
  import cle_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0]       opcode,
  input  logic [7:0]       value,
  input  logic [5:0]       seek_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [7:0]       item,
  output logic [LEN_W-1:0] item_index,
  output logic             at_cursor,
  output logic [LEN_W-1:0] match_count,
  output logic [LEN_W-1:0] list_length,
  output logic             is_empty,
  output logic [POS_W-1:0] cursor_position,
  output logic             last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_INS_RD  = 15'b000000000000010,
    S_INS_WR  = 15'b000000000000100,
    S_INS_PUT = 15'b000000000001000,
    S_DEL_RD  = 15'b000000000010000,
    S_DEL_WR  = 15'b000000000100000,
    S_DEL_END = 15'b000000001000000,
    S_SCAN_RD = 15'b000000010000000,
    S_SCAN_CK = 15'b000000100000000,
    S_STR_RD  = 15'b000001000000000,
    S_STR_OUT = 15'b000010000000000,
    S_DD_RDI  = 15'b000100000000000,
    S_DD_GETI = 15'b001000000000000,
    S_DD_RDJ  = 15'b010000000000000,
    S_DD_CHKJ = 15'b100000000000000
  } state_t;

  localparam state_t S_EMIT_UNUSED = S_IDLE;

  state_t         state;
  logic           emit;
  op_t            op;
  logic [7:0]     val;
  logic [CW-1:0]  count;
  logic [AW-1:0]  cur;
  logic [CW-1:0]  i;
  logic [CW-1:0]  j;
  logic [CW-1:0]  n;
  logic [7:0]     x;
  res_t           res;

  logic [7:0]     mem [DEPTH];
  logic [7:0]     rdata;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           we;
  logic [AW-1:0]  wa;
  logic [7:0]     wd;
  logic [AW-1:0]  str_addr;
  logic           str_last;
  logic           out_free;
  logic           in_fire;
  logic           match;
  logic [CW-1:0]  n_new;
  logic [CW-1:0]  ins_pos;
  logic [LEN_W-1:0] seek_ext;
  stat_t          start_status;

  assign in_stall = (state != S_IDLE) || emit;
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign match    = (rdata == val);
  assign n_new    = n + CW'(match);
  assign str_last = (op == OP_READ) || (i + CW'(1) == count);
  assign seek_ext = LEN_W'(seek_index);
  assign ins_pos  = (opcode == OP_INS_HEAD || count == '0) ? '0 : CW'(cur) + CW'(1);

  always_comb begin
    if (opcode == OP_INS_AFTER || opcode == OP_INS_HEAD) begin
      start_status = (count == CW'(DEPTH)) ? ST_FULL : ST_OK;
    end else if (opcode == OP_CLEAR || opcode == OP_DEDUPE) begin
      start_status = ST_OK;
    end else if (count == '0) begin
      start_status = ST_EMPTY;
    end else begin
      start_status = ST_OK;
    end
  end

  always_comb begin
    if (op == OP_READ) begin
      str_addr = cur;
    end else if (op == OP_REVERSE) begin
      str_addr = AW'(count - CW'(1) - i);
    end else begin
      str_addr = AW'(i);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wa      = '0;
    wd      = val;
    case (state)
      S_IDLE: begin
        if (in_fire && opcode == OP_REPLACE && count != '0) begin
          we = 1'b1;
          wa = cur;
          wd = value;
        end
      end
      S_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(i - CW'(1));
      end
      S_INS_WR: begin
        we = 1'b1;
        wa = AW'(i);
        wd = rdata;
      end
      S_INS_PUT: begin
        we = 1'b1;
        wa = AW'(j);
      end
      S_DEL_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(i + CW'(1));
      end
      S_DEL_WR: begin
        we = 1'b1;
        wa = AW'(i);
        wd = rdata;
      end
      S_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(i);
      end
      S_STR_RD: begin
        rd_en   = 1'b1;
        rd_addr = str_addr;
      end
      S_DD_RDI: begin
        rd_en   = (i != count);
        rd_addr = AW'(i);
      end
      S_DD_RDJ: begin
        if (j == n) begin
          we = 1'b1;
          wa = AW'(n);
          wd = x;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(j);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit && out_free) begin
        out_valid   <= 1'b1;
        status      <= res.status;
        item        <= res.item;
        item_index  <= res.idx;
        at_cursor   <= res.atc;
        match_count <= res.mc;
        last        <= 1'b1;
      end else if (state == S_STR_OUT && out_free) begin
        out_valid   <= 1'b1;
        status      <= ST_OK;
        item        <= rdata;
        item_index  <= LEN_W'(str_addr);
        at_cursor   <= (str_addr == cur);
        match_count <= '0;
        last        <= str_last;
      end
      if ((emit || state == S_STR_OUT) && out_free) begin
        list_length     <= LEN_W'(count);
        is_empty        <= (count == '0);
        cursor_position <= POS_W'(cur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      emit  <= 1'b0;
      count <= '0;
      cur   <= '0;
    end else begin
      if (emit && out_free) begin
        emit <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op         <= op_t'(opcode);
            val        <= value;
            res        <= {start_status, {($bits(res_t) - 2){1'b0}}};
            i          <= '0;
            n          <= '0;
            case (opcode)
              OP_INS_AFTER, OP_INS_HEAD: begin
                if (count == CW'(DEPTH)) begin
                  emit       <= 1'b1;
                end else begin
                  j     <= ins_pos;
                  i     <= count;
                  state <= (count > ins_pos) ? S_INS_RD : S_INS_PUT;
                end
              end
              OP_CLEAR: begin
                count <= '0;
                cur   <= '0;
                emit  <= 1'b1;
              end
              OP_DEDUPE: begin
                state <= S_DD_RDI;
              end
              default: begin
                if (count == '0) begin
                  emit       <= 1'b1;
                end else begin
                  case (opcode)
                    OP_FRONT: begin
                      cur  <= '0;
                      emit <= 1'b1;
                    end
                    OP_REAR: begin
                      cur  <= AW'(count - CW'(1));
                      emit <= 1'b1;
                    end
                    OP_PREV: begin
                      if (cur != '0) begin
                        cur <= cur - AW'(1);
                      end
                      emit <= 1'b1;
                    end
                    OP_NEXT: begin
                      if (CW'(cur) + CW'(1) < count) begin
                        cur <= cur + AW'(1);
                      end
                      emit <= 1'b1;
                    end
                    OP_SEEK: begin
                      if (seek_ext < LEN_W'(count)) begin
                        cur <= AW'(seek_index);
                      end else begin
                        cur <= AW'(count - CW'(1));
                      end
                      emit <= 1'b1;
                    end
                    OP_DELETE: begin
                      i     <= CW'(cur);
                      state <= (CW'(cur) + CW'(1) < count) ? S_DEL_RD : S_DEL_END;
                    end
                    OP_READ, OP_LIST, OP_REVERSE: begin
                      state <= S_STR_RD;
                    end
                    OP_FIND, OP_COUNT: begin
                      state <= S_SCAN_RD;
                    end
                    default: begin
                      emit <= 1'b1;
                    end
                  endcase
                end
              end
            endcase
          end
        end
        S_INS_RD: begin
          state <= S_INS_WR;
        end
        S_INS_WR: begin
          i     <= i - CW'(1);
          state <= (i - CW'(1) > j) ? S_INS_RD : S_INS_PUT;
        end
        S_INS_PUT: begin
          count <= count + CW'(1);
          cur   <= AW'(j);
          emit  <= 1'b1;
          state <= S_IDLE;
        end
        S_DEL_RD: begin
          state <= S_DEL_WR;
        end
        S_DEL_WR: begin
          i     <= i + CW'(1);
          state <= (i + CW'(2) < count) ? S_DEL_RD : S_DEL_END;
        end
        S_DEL_END: begin
          count <= count - CW'(1);
          if (CW'(cur) + CW'(1) == count) begin
            cur <= '0;
          end
          emit  <= 1'b1;
          state <= S_IDLE;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CK;
        end
        S_SCAN_CK: begin
          if (op == OP_FIND) begin
            if (match) begin
              res.item <= val;
              res.idx  <= LEN_W'(i + CW'(1));
              emit     <= 1'b1;
              state    <= S_IDLE;
            end else if (i + CW'(1) == count) begin
              res.item   <= val;
              res.status <= ST_NOT_FOUND;
              emit       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              i     <= i + CW'(1);
              state <= S_SCAN_RD;
            end
          end else begin
            n <= n_new;
            if (i + CW'(1) == count) begin
              res.mc     <= LEN_W'(n_new);
              res.status <= (n_new == '0) ? ST_NOT_FOUND : ST_OK;
              emit       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              i     <= i + CW'(1);
              state <= S_SCAN_RD;
            end
          end
        end
        S_STR_RD: begin
          state <= S_STR_OUT;
        end
        S_STR_OUT: begin
          if (out_free) begin
            i     <= i + CW'(1);
            state <= str_last ? S_IDLE : S_STR_RD;
          end
        end
        S_DD_RDI: begin
          if (i == count) begin
            count <= n;
            cur   <= '0;
            emit  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_DD_GETI;
          end
        end
        S_DD_GETI: begin
          x     <= rdata;
          j     <= '0;
          state <= S_DD_RDJ;
        end
        S_DD_RDJ: begin
          if (j == n) begin
            n     <= n + CW'(1);
            i     <= i + CW'(1);
            state <= S_DD_RDI;
          end else begin
            state <= S_DD_CHKJ;
          end
        end
        S_DD_CHKJ: begin
          if (rdata == x) begin
            i     <= i + CW'(1);
            state <= S_DD_RDI;
          end else begin
            j     <= j + CW'(1);
            state <= S_DD_RDJ;
          end
        end
        default: begin
          state <= S_EMIT_UNUSED;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("item count beyond depth");

  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    (count == '0 && cur == '0) || (CW'(cur) < count))
    else $error("cursor outside the list");

  a_partial_only_streamed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> (op == OP_LIST || op == OP_REVERSE))
    else $error("word without last mark outside a stream");

endmodule

>>> test/cle_checker.sv
// Checker for the cursor list editor: watches both channels, predicts the
// result words from its own copy of the list, and counts mismatches. Depends on cle_pkg.
`timescale 1ns / 1ps
module cle_checker
  import cle_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [3:0]       opcode,
  input  logic [7:0]       value,
  input  logic [5:0]       seek_index,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       status,
  input  logic [7:0]       item,
  input  logic [LEN_W-1:0] item_index,
  input  logic             at_cursor,
  input  logic [LEN_W-1:0] match_count,
  input  logic [LEN_W-1:0] list_length,
  input  logic             is_empty,
  input  logic [POS_W-1:0] cursor_position,
  input  logic             last,
  output int               fail_count,
  output int               pending_words
);

  typedef struct packed {
    logic [1:0]       st;
    logic [7:0]       ch;
    logic [LEN_W-1:0] pos;
    logic             atc;
    logic [LEN_W-1:0] mc;
    logic [LEN_W-1:0] len;
    logic             emp;
    logic [POS_W-1:0] cur;
    logic             fin;
  } word_t;

  logic [7:0] chars [DEPTH];
  int         num_chars;
  int         cur_pos;
  word_t      word_queue [$];

  function automatic word_t make_word(stat_t st, logic [7:0] ch, int pos, bit atc, int mc,
                                      bit fin);
    word_t w;
    w.st  = st;
    w.ch  = ch;
    w.pos = LEN_W'(pos);
    w.atc = atc;
    w.mc  = LEN_W'(mc);
    w.len = LEN_W'(num_chars);
    w.emp = (num_chars == 0);
    w.cur = POS_W'(cur_pos);
    w.fin = fin;
    return w;
  endfunction

  task automatic edit_list(op_t op, logic [7:0] v, int sk);
    int i;
    int j;
    int n;
    int ins;
    bit dup;
    bit was_last;
    if (op == OP_INS_AFTER || op == OP_INS_HEAD) begin
      if (num_chars >= DEPTH) begin
        word_queue.push_back(make_word(ST_FULL, 8'd0, 0, 1'b0, 0, 1'b1));
        return;
      end
      ins = (op == OP_INS_HEAD || num_chars == 0) ? 0 : cur_pos + 1;
      for (i = num_chars; i > ins; i--) chars[i] = chars[i-1];
      chars[ins] = v;
      num_chars++;
      cur_pos = ins;
      word_queue.push_back(make_word(ST_OK, 8'd0, 0, 1'b0, 0, 1'b1));
      return;
    end
    if (op == OP_CLEAR) begin
      num_chars = 0;
      cur_pos = 0;
      word_queue.push_back(make_word(ST_OK, 8'd0, 0, 1'b0, 0, 1'b1));
      return;
    end
    if (op == OP_DEDUPE) begin
      n = 0;
      for (i = 0; i < num_chars; i++) begin
        dup = 0;
        for (j = 0; j < n; j++) if (chars[j] == chars[i]) dup = 1;
        if (!dup) begin
          chars[n] = chars[i];
          n++;
        end
      end
      num_chars = n;
      cur_pos = 0;
      word_queue.push_back(make_word(ST_OK, 8'd0, 0, 1'b0, 0, 1'b1));
      return;
    end
    if (num_chars == 0) begin
      word_queue.push_back(make_word(ST_EMPTY, 8'd0, 0, 1'b0, 0, 1'b1));
      return;
    end
    case (op)
      OP_FRONT: cur_pos = 0;
      OP_REAR: cur_pos = num_chars - 1;
      OP_PREV: if (cur_pos > 0) cur_pos--;
      OP_NEXT: if (cur_pos + 1 < num_chars) cur_pos++;
      OP_SEEK: cur_pos = (sk < num_chars) ? sk : num_chars - 1;
      OP_DELETE: begin
        was_last = (cur_pos + 1 == num_chars);
        for (i = cur_pos; i + 1 < num_chars; i++) chars[i] = chars[i+1];
        num_chars--;
        if (was_last) cur_pos = 0;
      end
      OP_REPLACE: chars[cur_pos] = v;
      OP_READ: begin
        word_queue.push_back(make_word(ST_OK, chars[cur_pos], cur_pos, 1'b1, 0, 1'b1));
        return;
      end
      OP_LIST: begin
        for (i = 0; i < num_chars; i++)
          word_queue.push_back(make_word(ST_OK, chars[i], i, i == cur_pos, 0,
                                         i + 1 == num_chars));
        return;
      end
      OP_REVERSE: begin
        for (i = 0; i < num_chars; i++) begin
          j = num_chars - 1 - i;
          word_queue.push_back(make_word(ST_OK, chars[j], j, j == cur_pos, 0,
                                         i + 1 == num_chars));
        end
        return;
      end
      OP_FIND: begin
        for (i = 0; i < num_chars; i++)
          if (chars[i] == v) begin
            word_queue.push_back(make_word(ST_OK, v, i + 1, 1'b0, 0, 1'b1));
            return;
          end
        word_queue.push_back(make_word(ST_NOT_FOUND, v, 0, 1'b0, 0, 1'b1));
        return;
      end
      OP_COUNT: begin
        n = 0;
        for (i = 0; i < num_chars; i++) if (chars[i] == v) n++;
        word_queue.push_back(make_word(n == 0 ? ST_NOT_FOUND : ST_OK, 8'd0, 0, 1'b0, n,
                                       1'b1));
        return;
      end
      default: ;
    endcase
    word_queue.push_back(make_word(ST_OK, 8'd0, 0, 1'b0, 0, 1'b1));
  endtask

  word_t got;
  word_t want;

  always @(posedge clk) begin
    if (rst) begin
      num_chars  = 0;
      cur_pos    = 0;
      fail_count = 0;
      word_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {status, item, item_index, at_cursor, match_count, list_length, is_empty,
               cursor_position, last};
        if (word_queue.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          fail_count = fail_count + 1;
        end else begin
          want = word_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) edit_list(op_t'(opcode), value, int'(seek_index));
    end
    pending_words = word_queue.size();
  end

endmodule

>>> test/tb_cursor_list_editor_unit.sv
// Testbench top for the cursor list editor: drives commands in bursts, stalls
// the output, and gives the verdict. Depends on cle_pkg, the block and cle_checker.
`timescale 1ns / 1ps
module tb_cursor_list_editor_unit;
  import cle_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [3:0]       opcode = 4'd0;
  logic [7:0]       value = 8'd0;
  logic [5:0]       seek_index = 6'd0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       status;
  logic [7:0]       item;
  logic [LEN_W-1:0] item_index;
  logic             at_cursor;
  logic [LEN_W-1:0] match_count;
  logic [LEN_W-1:0] list_length;
  logic             is_empty;
  logic [POS_W-1:0] cursor_position;
  logic             last;
  int               fail_count;
  int               pending_words;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cursor_list_editor_unit u_top (.*);
  cle_checker u_chk (.*);

  always @(posedge clk) begin
    if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 1) == 0);
  end

  task automatic send_command(op_t op, logic [7:0] v, logic [5:0] sk);
    opcode     <= op;
    value      <= v;
    seek_index <= sk;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return op_t'($urandom_range(0, 1));
    if (r < 38) return OP_CLEAR;
    if (r < 41) return OP_DEDUPE;
    return op_t'($urandom_range(2, 13));
  endfunction

  initial begin
    int i;
    int burst;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_command(OP_READ, 8'h00, 6'd0);
    send_command(OP_LIST, 8'h00, 6'd0);
    send_command(OP_DELETE, 8'h00, 6'd0);
    send_command(OP_DEDUPE, 8'h00, 6'd0);
    send_command(OP_CLEAR, 8'h00, 6'd0);
    send_command(OP_INS_AFTER, 8'hFF, 6'd0);
    send_command(OP_INS_HEAD, 8'h00, 6'd0);
    send_command(OP_INS_AFTER, 8'hFF, 6'd0);
    send_command(OP_INS_AFTER, 8'hA5, 6'd0);
    send_command(OP_PREV, 8'h00, 6'd0);
    send_command(OP_FRONT, 8'h00, 6'd0);
    send_command(OP_PREV, 8'h00, 6'd0);
    send_command(OP_REAR, 8'h00, 6'd0);
    send_command(OP_NEXT, 8'h00, 6'd0);
    send_command(OP_SEEK, 8'h00, 6'd63);
    send_command(OP_SEEK, 8'h00, 6'd1);
    send_command(OP_REPLACE, 8'h5A, 6'd0);
    send_command(OP_READ, 8'h00, 6'd0);
    send_command(OP_FIND, 8'hFF, 6'd0);
    send_command(OP_FIND, 8'h12, 6'd0);
    send_command(OP_COUNT, 8'hFF, 6'd0);
    send_command(OP_COUNT, 8'h12, 6'd0);
    send_command(OP_REVERSE, 8'h00, 6'd0);
    send_command(OP_DEDUPE, 8'h00, 6'd0);
    send_command(OP_REAR, 8'h00, 6'd0);
    send_command(OP_DELETE, 8'h00, 6'd0);
    send_command(OP_LIST, 8'h00, 6'd0);
    // Insert at the head until the list is past full, try one more insert, then list it whole.
    for (i = 0; i < DEPTH_DEFAULT + 1; i++)
      send_command(OP_INS_HEAD, 8'($urandom_range(0, 255)), 6'd0);
    send_command(OP_INS_AFTER, 8'h01, 6'd0);
    send_command(OP_LIST, 8'h00, 6'd0);
    send_command(OP_SEEK, 8'h00, 6'd40);
    send_command(OP_DELETE, 8'h00, 6'd0);
    send_command(OP_CLEAR, 8'h00, 6'd0);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_words == 0);
    repeat (20) @(posedge clk);
    i = 0;
    while (i < 83) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && i < 83) begin
        send_command(pick_op(),
                     (i % 2) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)));
        burst--;
        i++;
      end
      if (i == 40) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_words == 0);
        @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 20));
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_words == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
design/cle_pkg.sv
design/cursor_list_editor_unit.sv
test/cle_checker.sv
test/tb_cursor_list_editor_unit.sv
